// ----- sv/cfrs_pkg.sv -----
`default_nettype none
package cfrs_pkg;

    // field widths
    localparam int TW   = 18;   // thickness
    localparam int BW   = 19;   // bed / sea elevation
    localparam int DW   = 48;   // stress words
    localparam int FW   = 32;   // prescribed velocity
    localparam int CDW  = 32;   // config data
    localparam int CIW  = 3;    // config index

    localparam logic [TW-1:0] ICE_MIN   = 18'd16;
    localparam logic [TW-1:0] THICK_MIN = 18'd1600;

    // divider geometry
    localparam int QB   = 49;       // quotient bits kept before saturation
    localparam int NW   = 77;       // numerator magnitude
    localparam int DENW = 39;       // 2048 * ro * dx
    localparam int DL   = QB + 1;   // divider register stages

    localparam int QDEPTH_DEF = 4;

    // item kinds
    localparam logic [1:0] K_PASS  = 2'd0;
    localparam logic [1:0] K_ZERO  = 2'd1;
    localparam logic [1:0] K_FIXED = 2'd2;
    localparam logic [1:0] K_FRONT = 2'd3;

    // front classes
    localparam logic [1:0] C_FLOAT  = 2'd0;
    localparam logic [1:0] C_CLIFF  = 2'd1;
    localparam logic [1:0] C_MARINE = 2'd2;

    // register indexes
    localparam logic [CIW-1:0] R_SEA   = 3'd0;
    localparam logic [CIW-1:0] R_RI    = 3'd1;
    localparam logic [CIW-1:0] R_RO    = 3'd2;
    localparam logic [CIW-1:0] R_G     = 3'd3;
    localparam logic [CIW-1:0] R_DX    = 3'd4;
    localparam logic [CIW-1:0] R_DY    = 3'd5;
    localparam logic [CIW-1:0] R_SCALE = 3'd6;

    typedef struct packed {
        logic signed [BW-1:0] sea;
        logic [9:0]           ri;
        logic [10:0]          ro;     // never zero
        logic [13:0]          g;
        logic [16:0]          dx;     // never zero
        logic [16:0]          dy;     // never zero
        logic [31:0]          scale;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [1:0]    kx;
        logic signed [1:0]    ky;
        logic                 flt;
        logic [TW-1:0]        thick;
        logic signed [BW-1:0] bed;
        logic signed [DW-1:0] pu;
        logic signed [DW-1:0] pv;
    } t_item;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [1:0]    kx;
        logic signed [1:0]    ky;
        logic                 nneg;
        logic signed [DW-1:0] pu;
        logic signed [DW-1:0] pv;
    } t_ctx;

    function automatic logic [DW-1:0] sat48(input logic [63:0] mag, input logic neg);
        logic [63:0] lim;
        logic [63:0] q;
        logic [63:0] r;
        lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        q   = (mag > lim) ? lim : mag;
        r   = neg ? (~q + 64'd1) : q;
        return r[DW-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/cfrs_front.sv -----
`default_nettype none
module cfrs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfrs_pkg::t_cfg               i_cfg,
    input  logic                         i_vld,
    output logic                         o_rdy,
    input  logic [cfrs_pkg::TW-1:0]      i_thick_c,
    input  logic [cfrs_pkg::TW-1:0]      i_thick_e,
    input  logic [cfrs_pkg::TW-1:0]      i_thick_w,
    input  logic [cfrs_pkg::TW-1:0]      i_thick_n,
    input  logic [cfrs_pkg::TW-1:0]      i_thick_s,
    input  logic signed [cfrs_pkg::BW-1:0] i_bed,
    input  logic signed [cfrs_pkg::DW-1:0] i_drive_u,
    input  logic signed [cfrs_pkg::DW-1:0] i_drive_v,
    input  logic                         i_fixed_flag,
    input  logic signed [cfrs_pkg::FW-1:0] i_fixed_u,
    input  logic signed [cfrs_pkg::FW-1:0] i_fixed_v,
    output logic                         o_vld,
    input  logic                         i_rdy,
    output cfrs_pkg::t_item              o_item
);
    import cfrs_pkg::*;

    logic ie, iw, inn, is;
    logic signed [1:0]  kx, ky;
    logic signed [19:0] sb;
    logic signed [31:0] sbro;
    logic [27:0]        rih;
    t_item n_item;
    t_item r_item;
    logic  r_vld;

    always_comb begin
        ie   = i_thick_e > ICE_MIN;
        iw   = i_thick_w > ICE_MIN;
        inn  = i_thick_n > ICE_MIN;
        is   = i_thick_s > ICE_MIN;
        kx   = $signed({1'b0, iw}) - $signed({1'b0, ie});
        ky   = $signed({1'b0, is}) - $signed({1'b0, inn});
        // floating when (S-B)*ro > ri*H
        sb   = $signed({i_cfg.sea[BW-1], i_cfg.sea}) - $signed({i_bed[BW-1], i_bed});
        sbro = sb * $signed({1'b0, i_cfg.ro});
        rih  = i_cfg.ri * i_thick_c;

        n_item       = '0;
        n_item.kx    = kx;
        n_item.ky    = ky;
        n_item.flt   = sbro > $signed({4'b0000, rih});
        n_item.thick = i_thick_c;
        n_item.bed   = i_bed;
        priority if (i_fixed_flag) begin
            n_item.kind = K_FIXED;
            n_item.pu   = {{(DW-FW){i_fixed_u[FW-1]}}, i_fixed_u};
            n_item.pv   = {{(DW-FW){i_fixed_v[FW-1]}}, i_fixed_v};
        end else if (i_thick_c <= ICE_MIN) begin
            n_item.kind = K_ZERO;
        end else if (i_thick_c > THICK_MIN && !(ie && iw && inn && is)) begin
            n_item.kind = K_FRONT;
        end else begin
            n_item.kind = K_PASS;
            n_item.pu   = i_drive_u;
            n_item.pv   = i_drive_v;
        end
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && o_rdy) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/cfrs_queue.sv -----
`default_nettype none
module cfrs_queue #(
    parameter int DEPTH = cfrs_pkg::QDEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  cfrs_pkg::t_item i_item,
    output logic            o_vld,
    input  logic            i_rdy,
    output cfrs_pkg::t_item o_item
);
    import cfrs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           push, pop;

    assign o_rdy  = r_cnt != CW'(DEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_item = r_mem[r_rp];
    assign push   = i_vld && o_rdy;
    assign pop    = o_vld && i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/cfrs_div.sv -----
`default_nettype none
module cfrs_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [cfrs_pkg::NW-1:0]   i_num,
    input  logic [cfrs_pkg::DENW-1:0] i_den,
    output logic [cfrs_pkg::QB-1:0]   o_q,
    output logic                      o_rnd,
    output logic                      o_ovf
);
    import cfrs_pkg::*;

    localparam int RW = DENW + QB;

    // restoring divider, one quotient bit per stage
    logic [RW-1:0]   r_rem [QB+1];
    logic [DENW-1:0] r_den [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic            r_ovf [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= RW'(i_num) >= {i_den, {QB{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int B = QB - k;
        logic [RW-1:0] sh;
        logic          ge;
        logic [QB-1:0] nq;
        always_comb begin
            sh    = RW'(r_den[k-1]) << B;
            ge    = r_rem[k-1] >= sh;
            nq    = r_q[k-1];
            nq[B] = ge;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? r_rem[k-1] - sh : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= nq;
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_q   = r_q[QB];
    assign o_ovf = r_ovf[QB];
    // half or more of the divisor left over rounds away from zero
    assign o_rnd = (r_rem[QB] << 1) >= RW'(r_den[QB]);

endmodule
`default_nettype wire

// ----- sv/cfrs_back.sv -----
`default_nettype none
module cfrs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cfrs_pkg::t_cfg            i_cfg,
    input  logic                      i_vld,
    output logic                      o_rdy,
    input  cfrs_pkg::t_item           i_item,
    output logic                      o_vld,
    input  logic                      i_rdy,
    output logic [cfrs_pkg::DW-1:0]   o_u,
    output logic [cfrs_pkg::DW-1:0]   o_v
);
    import cfrs_pkg::*;

    localparam int NV = 6 + DL;
    localparam int EW = 52;

    logic          en;
    logic [NV-1:0] r_v;
    logic          r_ovld;

    // stage 1 terms
    logic signed [11:0] dro;
    logic signed [19:0] sb0, bh0;
    logic signed [30:0] sro0, dh0;
    logic signed [31:0] hnf0, hnc0;
    logic signed [39:0] sq0;
    logic [31:0]        fmu0, fmv0;
    logic [1:0]         cls0;

    logic [TW-1:0]      r1_h;
    logic signed [31:0] r1_hn;
    logic [35:0]        r1_hh;
    logic [39:0]        r1_sb2;
    logic [1:0]         r1_cls;
    logic [23:0]        r1_a;
    logic [24:0]        r1_gro;
    logic [63:0]        r1_fpu, r1_fpv;
    logic               r1_fnu, r1_fnv;
    t_ctx               r1_c;

    // stage 2 terms
    logic signed [50:0] bp1;
    logic [50:0]        ba1;
    logic signed [11:0] m1;
    logic signed [48:0] hm1;
    logic [50:0]        ros1;
    logic signed [52:0] ev1;
    logic [52:0]        ea1;
    t_ctx               c1;

    logic               r2_bneg, r2_eneg;
    logic [48:0]        r2_bmag;
    logic [EW-1:0]      r2_emag;
    logic [24:0]        r2_c;
    logic [23:0]        r2_a;
    t_ctx               r2_c2;

    logic [48:0]        r3_tlo;
    logic [47:0]        r3_thi;
    logic [50:0]        r3_plo, r3_phi;
    logic               r3_bneg, r3_eneg;
    t_ctx               r3_c;

    logic [NW-1:0]      r4_t, r4_p;
    logic               r4_bneg, r4_eneg;
    t_ctx               r4_c;

    logic signed [NW+1:0] ts4, ps4;
    logic signed [NW+1:0] r5_n;
    t_ctx                 r5_c;

    logic [NW+1:0]      na5;
    t_ctx               c5;
    logic [NW-1:0]      r6_nmag;
    t_ctx               r6_c;

    logic [DENW-1:0]    den_u, den_v;
    logic [QB-1:0]      qu, qv;
    logic               rnd_u, rnd_v, ovf_u, ovf_v;
    t_ctx               r_cd [DL];

    // final stage
    t_ctx               cf;
    logic [QB:0]        qru, qrv;
    logic [63:0]        mgu, mgv;
    logic [DW-1:0]      ru, rv;
    logic [DW-1:0]      r_ou, r_ov;

    assign en    = !r_ovld || i_rdy;
    assign o_rdy = en;
    assign o_vld = r_ovld;
    assign o_u   = r_ou;
    assign o_v   = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_v    <= {r_v[NV-2:0], i_vld};
            r_ovld <= r_v[NV-1];
        end
    end

    // ---- stage 1: water line, H^2, (S-B)^2, fixed products
    always_comb begin
        dro  = $signed({1'b0, i_cfg.ro}) - $signed({2'b00, i_cfg.ri});
        sro0 = $signed(i_cfg.sea) * $signed({1'b0, i_cfg.ro});
        dh0  = dro * $signed({1'b0, i_item.thick});
        hnf0 = 32'(sro0) + 32'(dh0);
        bh0  = $signed({i_item.bed[BW-1], i_item.bed}) + $signed({2'b00, i_item.thick});
        hnc0 = bh0 * $signed({1'b0, i_cfg.ro});
        sb0  = $signed({i_cfg.sea[BW-1], i_cfg.sea}) - $signed({i_item.bed[BW-1], i_item.bed});
        sq0  = sb0 * sb0;
        fmu0 = i_item.pu[FW-1] ? 32'(-i_item.pu[FW-1:0]) : i_item.pu[FW-1:0];
        fmv0 = i_item.pv[FW-1] ? 32'(-i_item.pv[FW-1:0]) : i_item.pv[FW-1:0];
        priority if (i_item.flt) begin
            cls0 = C_FLOAT;
        end else if ($signed(i_item.bed) >= $signed(i_cfg.sea)) begin
            cls0 = C_CLIFF;
        end else begin
            cls0 = C_MARINE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_h   <= i_item.thick;
            r1_hn  <= i_item.flt ? hnf0 : hnc0;
            r1_hh  <= i_item.thick * i_item.thick;
            r1_sb2 <= sq0;
            r1_cls <= cls0;
            r1_a   <= i_cfg.ri * i_cfg.g;
            r1_gro <= i_cfg.g * i_cfg.ro;
            r1_fpu <= fmu0 * i_cfg.scale;
            r1_fpv <= fmv0 * i_cfg.scale;
            r1_fnu <= i_item.pu[FW-1];
            r1_fnv <= i_item.pv[FW-1];
            r1_c   <= '{kind: i_item.kind, kx: i_item.kx, ky: i_item.ky, nneg: 1'b0,
                        pu: i_item.pu, pv: i_item.pv};
        end
    end

    // ---- stage 2: H*hn and the pressure factor e, so P = c * e
    always_comb begin
        bp1  = $signed({1'b0, r1_h}) * r1_hn;
        ba1  = bp1[50] ? 51'(-bp1) : bp1;
        unique case (r1_cls)
            C_FLOAT:  m1 = dro;
            C_CLIFF:  m1 = $signed({1'b0, i_cfg.ro});
            default:  m1 = $signed({2'b00, i_cfg.ri});
        endcase
        hm1  = m1 * $signed({1'b0, r1_hh});
        ros1 = i_cfg.ro * r1_sb2;
        ev1  = 53'(hm1) - ((r1_cls == C_MARINE) ? $signed({2'b00, ros1}) : 53'sd0);
        ea1  = ev1[52] ? 53'(-ev1) : ev1;
        c1   = r1_c;
        if (r1_c.kind == K_FIXED) begin
            c1.pu = sat48(r1_fpu, r1_fnu);
            c1.pv = sat48(r1_fpv, r1_fnv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_bneg <= r1_hn[31];
            r2_bmag <= ba1[48:0];
            r2_eneg <= ev1[52];
            r2_emag <= ea1[EW-1:0];
            r2_c    <= (r1_cls == C_MARINE) ? r1_gro : {1'b0, r1_a};
            r2_a    <= r1_a;
            r2_c2   <= c1;
        end
    end

    // ---- stage 3: partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_tlo  <= r2_a * r2_bmag[24:0];
            r3_thi  <= r2_a * r2_bmag[48:25];
            r3_plo  <= r2_c * r2_emag[25:0];
            r3_phi  <= r2_c * r2_emag[EW-1:26];
            r3_bneg <= r2_bneg;
            r3_eneg <= r2_eneg;
            r3_c    <= r2_c2;
        end
    end

    // ---- stage 4: t = 2*a*b, P = c*e
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_t    <= (NW'(r3_thi) << 26) + (NW'(r3_tlo) << 1);
            r4_p    <= (NW'(r3_phi) << 26) + NW'(r3_plo);
            r4_bneg <= r3_bneg;
            r4_eneg <= r3_eneg;
            r4_c    <= r3_c;
        end
    end

    // ---- stage 5: N = t - P
    always_comb begin
        ts4 = r4_bneg ? -$signed({2'b00, r4_t}) : $signed({2'b00, r4_t});
        ps4 = r4_eneg ? -$signed({2'b00, r4_p}) : $signed({2'b00, r4_p});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_n <= ts4 - ps4;
            r5_c <= r4_c;
        end
    end

    // ---- stage 6: magnitude and sign of N
    always_comb begin
        na5     = r5_n[NW+1] ? (NW+2)'(-r5_n) : r5_n;
        c5      = r5_c;
        c5.nneg = r5_n[NW+1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_nmag <= na5[NW-1:0];
            r6_c    <= c5;
        end
    end

    // ---- dividers
    assign den_u = {28'(i_cfg.ro * i_cfg.dx), 11'b0};
    assign den_v = {28'(i_cfg.ro * i_cfg.dy), 11'b0};

    cfrs_div u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r6_nmag),
        .i_den (den_u),
        .o_q   (qu),
        .o_rnd (rnd_u),
        .o_ovf (ovf_u)
    );

    cfrs_div u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r6_nmag),
        .i_den (den_v),
        .o_q   (qv),
        .o_rnd (rnd_v),
        .o_ovf (ovf_v)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd[0] <= r6_c;
            for (int k = 1; k < DL; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
    end

    // ---- round, sign, saturate, pick
    always_comb begin
        cf  = r_cd[DL-1];
        qru = {1'b0, qu} + (QB+1)'(rnd_u);
        qrv = {1'b0, qv} + (QB+1)'(rnd_v);
        mgu = ovf_u ? '1 : 64'(qru);
        mgv = ovf_v ? '1 : 64'(qrv);
        ru  = (cf.kx == 2'sd0) ? '0 : sat48(mgu, cf.nneg ^ cf.kx[1]);
        rv  = (cf.ky == 2'sd0) ? '0 : sat48(mgv, cf.nneg ^ cf.ky[1]);
        if (cf.kind != K_FRONT) begin
            ru = cf.pu;
            rv = cf.pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ou <= ru;
            r_ov <= rv;
        end
    end

endmodule
`default_nettype wire

// ----- sv/calving_front_rhs_stress_top.sv -----
`default_nettype none
// Channel   Dir  Handshake                 Payload
// s (cell)  in   i_s_tvalid / o_s_tready   i_s_tdata (272b), i_s_tuser = fixed_flag
// m (rhs)   out  o_m_tvalid / i_m_tready   o_m_tdata (96b)
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index (3b), i_cfg_data (32b)
//
// One cell per clock sustained while m is not stalled; the path runs through the
// input register, queue, six arithmetic stages, 50-stage divider and output
// register. The restoring divider, one quotient bit per stage, sets the depth.
// Reset (sync, active low) clears handshake state and loads register defaults.
// A stall on m holds the back pipe; the 4-beat queue lets the front keep
// taking beats until it fills.
module calving_front_rhs_stress_top #(
    parameter int P_QDEPTH = cfrs_pkg::QDEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // cell beat
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // thick_c[17:0] thick_e[35:18] thick_w[53:36] thick_n[71:54] thick_s[89:72]
    // bed_elev[108:90] drive_u[156:109] drive_v[204:157]
    // fixed_u[236:205] fixed_v[268:237] zero pad[271:269]
    input  logic [271:0]                i_s_tdata,
    input  logic                        i_s_tuser,      // fixed_flag
    // result beat
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [95:0]                 o_m_tdata,      // rhs_u[47:0] rhs_v[95:48]
    // register writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cfrs_pkg::CIW-1:0]    i_cfg_index,
    input  logic [cfrs_pkg::CDW-1:0]    i_cfg_data
);
    import cfrs_pkg::*;

    logic signed [BW-1:0] r_sea;
    logic [9:0]           r_ri;
    logic [10:0]          r_ro;
    logic [13:0]          r_g;
    logic [16:0]          r_dx, r_dy;
    logic [31:0]          r_scale;
    t_cfg                 cfg;

    logic  f_vld, f_rdy, q_vld, q_rdy;
    t_item f_item, q_item;
    logic [DW-1:0] rhs_u, rhs_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sea   <= '0;
            r_ri    <= 10'd910;
            r_ro    <= 11'd1028;
            r_g     <= 14'd10045;
            r_dx    <= 17'd1000;
            r_dy    <= 17'd1000;
            r_scale <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                R_SEA:   r_sea   <= i_cfg_data[BW-1:0];
                R_RI:    r_ri    <= i_cfg_data[9:0];
                R_RO:    r_ro    <= i_cfg_data[10:0];
                R_G:     r_g     <= i_cfg_data[13:0];
                R_DX:    r_dx    <= i_cfg_data[16:0];
                R_DY:    r_dy    <= i_cfg_data[16:0];
                R_SCALE: r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero density or spacing acts as one
    always_comb begin
        cfg.sea   = r_sea;
        cfg.ri    = r_ri;
        cfg.ro    = (r_ro == '0) ? 11'd1 : r_ro;
        cfg.g     = r_g;
        cfg.dx    = (r_dx == '0) ? 17'd1 : r_dx;
        cfg.dy    = (r_dy == '0) ? 17'd1 : r_dy;
        cfg.scale = r_scale;
    end

    cfrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_vld        (i_s_tvalid),
        .o_rdy        (o_s_tready),
        .i_thick_c    (i_s_tdata[17:0]),
        .i_thick_e    (i_s_tdata[35:18]),
        .i_thick_w    (i_s_tdata[53:36]),
        .i_thick_n    (i_s_tdata[71:54]),
        .i_thick_s    (i_s_tdata[89:72]),
        .i_bed        (i_s_tdata[108:90]),
        .i_drive_u    (i_s_tdata[156:109]),
        .i_drive_v    (i_s_tdata[204:157]),
        .i_fixed_flag (i_s_tuser),
        .i_fixed_u    (i_s_tdata[236:205]),
        .i_fixed_v    (i_s_tdata[268:237]),
        .o_vld        (f_vld),
        .i_rdy        (f_rdy),
        .o_item       (f_item)
    );

    cfrs_queue #(.DEPTH(P_QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .o_rdy   (f_rdy),
        .i_item  (f_item),
        .o_vld   (q_vld),
        .i_rdy   (q_rdy),
        .o_item  (q_item)
    );

    cfrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (q_vld),
        .o_rdy   (q_rdy),
        .i_item  (q_item),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_u     (rhs_u),
        .o_v     (rhs_v)
    );

    assign o_m_tdata = {rhs_v, rhs_u};

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import cfrs_pkg::*;

    typedef struct {
        logic [17:0]        hc, he, hw, hn, hs;
        logic signed [18:0] bed;
        logic signed [47:0] du, dv;
        logic               fixed;
        logic signed [31:0] fu, fv;
    } cell_t;

    localparam logic signed [159:0] POS48 = 160'sh7FFF_FFFF_FFFF;
    localparam logic signed [159:0] NEG48 = -(160'sh8000_0000_0000);
    localparam int IDLE_LIMIT = 20000;   // cycles without any beat
    localparam int HOLD_LEN   = 300;     // long receiver stall
    localparam int DRAIN_WAIT = 80;      // a bit over the pipe latency

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [271:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [95:0]  o_m_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [CIW-1:0] i_cfg_index = '0;
    logic [CDW-1:0] i_cfg_data = '0;

    calving_front_rhs_stress_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register shadow, follows every accepted write
    logic signed [18:0] sea_m = '0;
    logic [9:0]  ri_m = 10'd910;
    logic [10:0] ro_m = 11'd1028;
    logic [13:0] g_m = 14'd10045;
    logic [16:0] dx_m = 17'd1000, dy_m = 17'd1000;
    logic [31:0] scale_m = 32'd1;

    cell_t        cell_q[$];
    logic [95:0]  rhs_q[$];
    int           errors = 0;
    int           send_idle = 0, recv_idle = 0;
    logic         hold_go = 1'b0;
    int           hold_cnt = 0;
    int           quiet = 0;

    function automatic logic [47:0] clamp48(logic signed [159:0] v);
        if (v > POS48) return POS48[47:0];
        if (v < NEG48) return NEG48[47:0];
        return v[47:0];
    endfunction

    // k * n / den, half away from zero, saturated
    function automatic logic [47:0] front_quot(logic signed [159:0] n, int k,
                                               logic [159:0] den);
        logic [159:0] mag, q, r;
        logic signed [159:0] v;
        if (k == 0) return '0;
        mag = (n < 0) ? -n : n;
        q = mag / den;
        r = mag % den;
        if (r >= den - r) q = q + 1;
        v = q;
        if (((k < 0) != (n < 0)) && q != 0) v = -v;
        return clamp48(v);
    endfunction

    function automatic logic [95:0] calc_rhs(cell_t c);
        logic signed [159:0] H, S, B, ri, ro, g, d, hnorm, pres, n, fu, fv, sc;
        logic [159:0] dxd, dyd;
        logic ie, iw, inn, is;
        int kx, ky;
        if (c.fixed) begin
            fu = c.fu; fv = c.fv; sc = {128'd0, scale_m};
            return {clamp48(fv * sc), clamp48(fu * sc)};
        end
        if (c.hc <= ICE_MIN) return '0;
        ie = c.he > ICE_MIN; iw = c.hw > ICE_MIN; inn = c.hn > ICE_MIN; is = c.hs > ICE_MIN;
        if (!(c.hc > THICK_MIN && (!ie || !iw || !inn || !is)))
            return {c.dv, c.du};
        H = {142'd0, c.hc}; S = sea_m; B = c.bed;
        ri = {150'd0, ri_m}; ro = {149'd0, ro_m}; g = {146'd0, g_m};
        if (ro == 0) ro = 1;
        if (B * ro < S * ro - ri * H) begin              // floating shelf
            d = ro - ri;
            hnorm = S * ro + d * H;
            pres = ri * g * d * H * H;
        end else begin
            hnorm = (B + H) * ro;
            if (B >= S) pres = ri * g * ro * H * H;      // dry cliff
            else pres = g * ro * (ri * H * H - ro * (S - B) * (S - B)); // marine
        end
        n = 2 * ri * g * H * hnorm - pres;
        kx = (iw ? 1 : 0) - (ie ? 1 : 0);
        ky = (is ? 1 : 0) - (inn ? 1 : 0);
        dxd = 2048 * ro * ((dx_m == 0) ? 1 : dx_m);
        dyd = 2048 * ro * ((dy_m == 0) ? 1 : dy_m);
        return {front_quot(n, ky, dyd), front_quot(n, kx, dxd)};
    endfunction

    // cell driver
    always @(posedge i_clk) begin
        cell_t c;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                c.hc = i_s_tdata[17:0];    c.he = i_s_tdata[35:18];
                c.hw = i_s_tdata[53:36];   c.hn = i_s_tdata[71:54];
                c.hs = i_s_tdata[89:72];   c.bed = i_s_tdata[108:90];
                c.du = i_s_tdata[156:109]; c.dv = i_s_tdata[204:157];
                c.fu = i_s_tdata[236:205]; c.fv = i_s_tdata[268:237];
                c.fixed = i_s_tuser;
                rhs_q.push_back(calc_rhs(c));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (cell_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    c = cell_q.pop_front();
                    i_s_tdata <= {3'b0, c.fv, c.fu, c.dv, c.du, c.bed,
                                  c.hs, c.hn, c.hw, c.he, c.hc};
                    i_s_tuser <= c.fixed;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor, receiver stalls and the one long hold-off
    always @(posedge i_clk) begin
        logic [95:0] want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (rhs_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    want = rhs_q.pop_front();
                    if (want[47:0] !== o_m_tdata[47:0]) begin
                        $display("%0t: rhs_u expected %h actual %h",
                                 $time, want[47:0], o_m_tdata[47:0]);
                        errors++;
                    end
                    if (want[95:48] !== o_m_tdata[95:48]) begin
                        $display("%0t: rhs_v expected %h actual %h",
                                 $time, want[95:48], o_m_tdata[95:48]);
                        errors++;
                    end
                end
            end
            if (hold_go && hold_cnt < HOLD_LEN) begin
                hold_cnt++;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic cfg_write(logic [CIW-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            R_SEA:   sea_m = val[18:0];
            R_RI:    ri_m = val[9:0];
            R_RO:    ro_m = val[10:0];
            R_G:     g_m = val[13:0];
            R_DX:    dx_m = val[16:0];
            R_DY:    dy_m = val[16:0];
            R_SCALE: scale_m = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (cell_q.size() == 0 && !i_s_tvalid && rhs_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_all(int sea, int ri, int ro, int g, int dx, int dy,
                           logic [31:0] sc);
        cfg_write(R_SEA, sea); cfg_write(R_RI, ri); cfg_write(R_RO, ro);
        cfg_write(R_G, g);     cfg_write(R_DX, dx); cfg_write(R_DY, dy);
        cfg_write(R_SCALE, sc);
    endtask

    function automatic logic [17:0] rnd_thick();
        case ($urandom_range(3))
            0: return $urandom_range(16);
            1: return $urandom_range(1700, 17);
            default: return $urandom_range(160000);
        endcase
    endfunction

    function automatic cell_t rnd_cell();
        cell_t c;
        int b;
        c.hc = rnd_thick(); c.he = rnd_thick(); c.hw = rnd_thick();
        c.hn = rnd_thick(); c.hs = rnd_thick();
        c.du = {$urandom, $urandom} >> 16;
        c.dv = {$urandom, $urandom} >> 16;
        c.fu = $urandom; c.fv = $urandom;
        c.fixed = ($urandom_range(9) < 2);
        if ($urandom_range(1)) begin
            c.bed = $urandom_range(320000) - 160000;
        end else begin
            // bed near sea level reaches all three front classes
            b = int'(sea_m) + int'($urandom_range(6000)) - 3000 - int'(c.hc) / 8;
            if (b > 160000) b = 160000;
            if (b < -160000) b = -160000;
            c.bed = b;
        end
        // half of the non-fixed cells become front cells: thick centre with at least one open side
        if (!c.fixed && $urandom_range(9) < 5) begin
            c.hc = $urandom_range(160000, 1601);
            case ($urandom_range(3))
                0: c.he = $urandom_range(16);
                1: c.hw = $urandom_range(16);
                2: c.hn = $urandom_range(16);
                default: c.hs = $urandom_range(16);
            endcase
        end
        return c;
    endfunction

    function automatic cell_t mk(int hc, int he, int hw, int hn, int hs, int bed);
        cell_t c;
        c.hc = hc; c.he = he; c.hw = hw; c.hn = hn; c.hs = hs; c.bed = bed;
        c.du = 48'sh7FFF_FFFF_FFFF; c.dv = 48'sh8000_0000_0000;
        c.fixed = 1'b0; c.fu = 0; c.fv = 0;
        return c;
    endfunction

    task automatic push_rand(int count);
        repeat (count) cell_q.push_back(rnd_cell());
    endtask

    initial begin
        cell_t c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cells at reset settings
        send_idle = 26; recv_idle = 88;
        c = mk(0, 0, 0, 0, 0, 0);             cell_q.push_back(c); // no ice
        c = mk(16, 160000, 160000, 160000, 160000, 0); cell_q.push_back(c);
        c = mk(17, 0, 0, 0, 0, 0);            cell_q.push_back(c); // thin, passes
        c = mk(1600, 0, 0, 0, 0, 0);          cell_q.push_back(c); // not thick
        c = mk(1601, 0, 17, 17, 17, -160000); cell_q.push_back(c); // east open
        c = mk(160000, 17, 0, 17, 17, -160000); cell_q.push_back(c); // floating
        c = mk(160000, 17, 17, 0, 17, 160000);  cell_q.push_back(c); // cliff
        c = mk(160000, 17, 17, 17, 0, -2000);   cell_q.push_back(c); // marine
        c = mk(80000, 0, 0, 0, 0, -1000);     cell_q.push_back(c); // isolated
        c = mk(80000, 0, 0, 16, 16, 0);       cell_q.push_back(c);
        c = mk(160000, 160000, 160000, 160000, 160000, 0); cell_q.push_back(c);
        c = mk(2000, 17, 17, 17, 17, 0); c.du = 0; c.dv = -1; cell_q.push_back(c);
        c = mk(0, 0, 0, 0, 0, 0); c.fixed = 1'b1;
        c.fu = 32'sh7FFF_FFFF; c.fv = 32'sh8000_0000; cell_q.push_back(c);
        c.fu = -1; c.fv = 0; cell_q.push_back(c);
        c = mk(160000, 0, 0, 0, 0, 0); c.fixed = 1'b1; c.fu = 5; c.fv = -5;
        cell_q.push_back(c);
        push_rand(40);
        drain();
        push_rand(30);
        hold_go = 1'b1;                       // long output stall, input backs up
        drain();

        // low extremes
        set_all(-160000, 800, 1000, 9000, 1, 1, 32'd1);
        push_rand(60);
        drain();

        // high extremes, receiver now quick and sender slow
        send_idle = 88; recv_idle = 26;
        set_all(160000, 1000, 1100, 11000, 100000, 100000, 32'hFFFF_FFFF);
        push_rand(60);
        drain();
        cfg_write(R_DX, 1);
        cfg_write(R_SCALE, 32'h0001_0000);
        push_rand(50);
        drain();

        // no idling, random settings
        send_idle = 0; recv_idle = 0;
        repeat (3) begin
            set_all(int'($urandom_range(320000)) - 160000, $urandom_range(1000, 800),
                    $urandom_range(1100, 1000), $urandom_range(11000, 9000),
                    $urandom_range(100000, 1), $urandom_range(100000, 1),
                    $urandom_range(32'hFFFF_FFFF, 1));
            push_rand(50);
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
